// File: design/assert_macros.svh
// Assertion macros used by the parser's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk_i, suspended while rst_ni is low.
`define IHEX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge of clk_i, reset included.
`define IHEX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IHEX_ASSERT(label, prop, msg)
`define IHEX_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: design/ihex_pkg.sv
// Types, constants and the hex digit decoder of the hex record parser.
`default_nettype none
package ihex_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned AddrW  = 17;
  localparam int unsigned PosW   = 10;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [PosW-1:0]  POS_MAX       = 10'd1023;
  localparam logic [AddrW-1:0] LOWER_RESET   = 17'h00400;
  localparam logic [AddrW-1:0] UPPER_RESET   = 17'h08000;

  localparam logic [CharW-1:0] CHAR_NEWLINE  = 8'd10;
  localparam logic [CharW-1:0] CHAR_COLON    = 8'h3A;
  localparam logic [CharW-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [CharW-1:0] CHAR_ONE      = 8'h31;
  localparam logic [CharW-1:0] CHAR_FOUR     = 8'h34;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_LOWER_BOUND = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_UPPER_BOUND = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_EOF    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REC_IGNORED  = 2'd0,
    REC_DATA     = 2'd1,
    REC_EXTENDED = 2'd2,
    REC_EOF      = 2'd3
  } rec_type_e;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] address;
    logic [7:0]       data;
    logic             bounds_error_seen;
    logic             extended_seen;
  } ihex_result_t;

  // Any character that is not a hex digit decodes as zero.
  function automatic logic [3:0] hex_value(input logic [CharW-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: design/ihex_parse.sv
// Record parser: line state and the decode of one character into at most one result.
`default_nettype none
module ihex_parse (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire logic [ihex_pkg::CharW-1:0] char_i,
  input  wire logic [ihex_pkg::AddrW-1:0] lower_bound_i,
  input  wire logic [ihex_pkg::AddrW-1:0] upper_bound_i,
  output logic                            produced_o,
  output ihex_pkg::ihex_result_t          result_o
);
  import ihex_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic             rec_line_q, rec_line_d;
  logic [7:0]       byte_count_q, byte_count_d;
  logic [15:0]      load_addr_q, load_addr_d;
  logic [CharW-1:0] first_type_q, first_type_d;
  rec_type_e        rec_type_q, rec_type_d;
  logic [3:0]       nibble_q, nibble_d;
  logic             ext_q, ext_d;
  logic             bounds_q, bounds_d;
  logic             finished_q, finished_d;

  logic [3:0]       nib;
  logic [PosW-1:0]  pos_off;
  logic [8:0]       byte_idx;
  logic [AddrW-1:0] byte_addr;
  logic             in_bounds;

  assign nib       = hex_value(char_i);
  assign pos_off   = pos_q - 10'd10;
  assign byte_idx  = pos_off[PosW-1:1];
  assign byte_addr = {1'b0, load_addr_q} + {8'd0, byte_idx};
  assign in_bounds = (byte_addr >= lower_bound_i) && (byte_addr < upper_bound_i);

  always_comb begin
    pos_d        = pos_q;
    rec_line_d   = rec_line_q;
    byte_count_d = byte_count_q;
    load_addr_d  = load_addr_q;
    first_type_d = first_type_q;
    rec_type_d   = rec_type_q;
    nibble_d     = nibble_q;
    ext_d        = ext_q;
    bounds_d     = bounds_q;
    finished_d   = finished_q;
    produced_o   = 1'b0;
    result_o     = '0;

    if (!finished_q) begin
      if (char_i == CHAR_NEWLINE) begin
        pos_d      = '0;
        rec_line_d = 1'b0;
        rec_type_d = REC_IGNORED;
      end else begin
        pos_d = (pos_q != POS_MAX) ? pos_q + 10'd1 : POS_MAX;
        if (pos_q == 10'd0) begin
          rec_line_d   = (char_i == CHAR_COLON);
          byte_count_d = '0;
          load_addr_d  = '0;
          rec_type_d   = REC_IGNORED;
        end else if (rec_line_q) begin
          priority if (pos_q == 10'd1) begin
            nibble_d = nib;
          end else if (pos_q == 10'd2) begin
            byte_count_d = {nibble_q, nib};
          end else if (pos_q <= 10'd6) begin
            load_addr_d = {load_addr_q[11:0], nib};
          end else if (pos_q == 10'd7) begin
            first_type_d = char_i;
          end else if (pos_q == 10'd8) begin
            rec_type_d = REC_IGNORED;
            if (first_type_q == CHAR_ZERO && char_i == CHAR_ZERO) begin
              if (!ext_q) rec_type_d = REC_DATA;
            end else if (first_type_q == CHAR_ZERO && char_i == CHAR_FOUR) begin
              rec_type_d = REC_EXTENDED;
              ext_d      = 1'b1;
            end else if (first_type_q == CHAR_ZERO && char_i == CHAR_ONE) begin
              rec_type_d                 = REC_EOF;
              finished_d                 = 1'b1;
              produced_o                 = 1'b1;
              result_o.kind              = KIND_EOF;
              result_o.bounds_error_seen = bounds_q;
              result_o.extended_seen     = ext_q;
            end
          end else if (pos_q[0]) begin
            nibble_d = nib;
          end else begin
            if (rec_type_q == REC_DATA && byte_idx < {1'b0, byte_count_q}) begin
              if (!in_bounds) bounds_d = 1'b1;
              produced_o                 = 1'b1;
              result_o.kind              = in_bounds ? KIND_ACCEPT : KIND_REJECT;
              result_o.address           = byte_addr;
              result_o.data              = {nibble_q, nib};
              result_o.bounds_error_seen = bounds_q | ~in_bounds;
              result_o.extended_seen     = ext_q;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      rec_line_q   <= 1'b0;
      byte_count_q <= '0;
      load_addr_q  <= '0;
      first_type_q <= '0;
      rec_type_q   <= REC_IGNORED;
      nibble_q     <= '0;
      ext_q        <= 1'b0;
      bounds_q     <= 1'b0;
      finished_q   <= 1'b0;
    end else if (fire_i) begin
      pos_q        <= pos_d;
      rec_line_q   <= rec_line_d;
      byte_count_q <= byte_count_d;
      load_addr_q  <= load_addr_d;
      first_type_q <= first_type_d;
      rec_type_q   <= rec_type_d;
      nibble_q     <= nibble_d;
      ext_q        <= ext_d;
      bounds_q     <= bounds_d;
      finished_q   <= finished_d;
    end
  end

endmodule
`default_nettype wire

// File: design/ihex_out_buf.sv
// Result register with one skid entry behind it.
`default_nettype none
module ihex_out_buf (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire ihex_pkg::ihex_result_t push_data_i,
  output logic                        full_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output ihex_pkg::ihex_result_t      out_data_o
);
  import ihex_pkg::*;

  logic         out_valid_q, skid_valid_q;
  ihex_result_t out_q, skid_q;
  logic         pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A push is only offered while the skid entry is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/intel_hex_record_parser.sv
// Top level of the hex record parser: input register, bound registers, parser, result buffer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | in        | in_valid_i / in_stall_o | in_character_i
//  out     | out       | out_valid_o/out_stall_i | out_kind_o, out_address_o, out_data_o,
//          |           |                         | out_bounds_error_seen_o, out_extended_seen_o
//  cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One character item is taken per cycle while in_stall_o is low. An accepted character is
// held in the input register, decoded against the line state and, if it ends a data byte or
// an end-of-file record, its result goes to the output register, or to the skid entry.
// Reset clears the line state and the sticky flags and loads the bounds with 1024 and 32768.
// A stalled output first fills the skid entry; only then is the input stalled.
`default_nettype none
module intel_hex_record_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [ihex_pkg::CharW-1:0] in_character_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      out_kind_o,
  output logic [ihex_pkg::AddrW-1:0]      out_address_o,
  output logic [7:0]                      out_data_o,
  output logic                            out_bounds_error_seen_o,
  output logic                            out_extended_seen_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [ihex_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ihex_pkg::AddrW-1:0] cfg_data_i
);
  import ihex_pkg::*;
  `include "assert_macros.svh"

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic [AddrW-1:0] lower_q, upper_q;
  logic             buf_full, fire, produced;
  ihex_result_t     result, out_res;

  // The held character is decoded whenever the result buffer has room for its result.
  assign fire       = in_valid_q && !buf_full;
  assign in_stall_o = in_valid_q && buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_char_q <= in_character_i;
  end

  // Bound registers; the user sees they are written only while no item is in flight; no check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LOWER_BOUND: lower_q <= cfg_data_i;
        REG_UPPER_BOUND: upper_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  ihex_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .char_i        (in_char_q),
    .lower_bound_i (lower_q),
    .upper_bound_i (upper_q),
    .produced_o    (produced),
    .result_o      (result)
  );

  ihex_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire && produced),
    .push_data_i (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign out_kind_o              = out_res.kind;
  assign out_address_o           = out_res.address;
  assign out_data_o              = out_res.data;
  assign out_bounds_error_seen_o = out_res.bounds_error_seen;
  assign out_extended_seen_o     = out_res.extended_seen;

  // Only the three result kinds ever leave the block.
  `IHEX_ASSERT(a_kind_legal, out_valid_o |-> (out_kind_o != 2'd3), "illegal result kind")
  // The end-of-file result is the last one: nothing follows once it has been taken.
  `IHEX_ASSERT(a_eof_last, (out_valid_o && !out_stall_i && out_kind_o == KIND_EOF) |=> !out_valid_o, "result after end of file")
  // The bounds error flag never falls between consecutive results.
  `IHEX_ASSERT(a_bounds_sticky, (out_valid_o && !out_stall_i && out_bounds_error_seen_o) |=> (!out_valid_o || out_bounds_error_seen_o), "bounds error flag dropped")

endmodule
`default_nettype wire

// File: tb/intel_hex_record_parser_tb.sv
// Self-checking testbench of the hex record parser: directed records, random text, then directed records again.
module intel_hex_record_parser_tb;
  import ihex_pkg::*;

  // The clock period is 4 units. The run is cut off well beyond the slowest correct run,
  // that is, one with every character waiting out the longest stalls.
  localparam int unsigned RunLimit    = 4000000;
  // Cycles to let pass once nothing is outstanding, to cover characters still in the
  // input register or the decode stage that cause no result.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 120;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned MaxPrinted   = 40;
  localparam logic [AddrW-1:0] AddrSpan = 17'h10000;

  // Directed records. The first OpenRows lines run straight after reset; the rest close
  // the run, since a type 04 record and an end-of-file record cannot be undone without
  // a second reset.
  localparam int unsigned DirRows  = 7;
  localparam int unsigned OpenRows = 2;

  string dir_text [DirRows] = '{
    ":027FFF00FF00\n",  // top of the reset window: 7FFF taken, 8000 refused
    ":0203FF00a5C3\n",  // bottom of the reset window, lower-case digits
    ":02FFFF00AbCd\n",  // highest load address, the second byte runs past 16 bits
    ":0200000400FF\n",  // extended address record
    ":0112340099\n",    // data record after an extended record is ignored
    ":00000001FF\n",    // end of file
    ":0100000011\n"     // everything after end of file is ignored
  };
  // Rows whose results are typed in below rather than taken from the predictor.
  bit dir_typed [DirRows] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             char_valid = 1'b0;
  logic             char_stall;
  logic [CharW-1:0] char_value = '0;
  logic             char_typed = 1'b0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  logic [1:0]       res_kind;
  logic [AddrW-1:0] res_address;
  logic [7:0]       res_data;
  logic             res_bounds;
  logic             res_ext;
  logic             cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_LOWER_BOUND;
  logic [AddrW-1:0] cfg_data = '0;

  // Predicted parser state and bound registers.
  logic [PosW-1:0]  pos_in_line = '0;
  bit               in_record = 1'b0;
  logic [7:0]       rec_bytes = '0;
  logic [AddrW-1:0] rec_addr = '0;
  logic [7:0]       type_first = '0;
  rec_type_e        rec_kind = REC_IGNORED;
  logic [3:0]       held_nibble = '0;
  bit               ext_sticky = 1'b0;
  bit               bnd_sticky = 1'b0;
  bit               eof_reached = 1'b0;
  logic [AddrW-1:0] lo_limit = LOWER_RESET;
  logic [AddrW-1:0] hi_limit = UPPER_RESET;

  ihex_result_t results_due [$];
  ihex_result_t fixed_results [$];
  logic [7:0]   line_buf [$];
  int unsigned  mismatches = 0;
  int unsigned  send_calm = 0;
  int unsigned  stall_left = 0;

  intel_hex_record_parser u_top (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (char_valid),
    .in_stall_o             (char_stall),
    .in_character_i         (char_value),
    .out_valid_o            (res_valid),
    .out_stall_i            (res_stall),
    .out_kind_o             (res_kind),
    .out_address_o          (res_address),
    .out_data_o             (res_data),
    .out_bounds_error_seen_o(res_bounds),
    .out_extended_seen_o    (res_ext),
    .cfg_we_i               (cfg_we),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Anything that is not a hex digit counts as zero.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] off;
    off = 8'd0;
    if (c >= "0" && c <= "9") begin
      off = c - "0";
    end else if (c >= "A" && c <= "F") begin
      off = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      off = c - "a" + 8'd10;
    end
    return off[3:0];
  endfunction

  // Advances the predicted line state by one character and says whether the character
  // completes a data byte of a live data record or an end-of-file record.
  function automatic bit step_parser(input logic [7:0] c, output ihex_result_t r);
    logic [PosW-1:0]  p;
    logic [3:0]       n;
    int unsigned      k;
    logic [AddrW-1:0] a;
    bit               made;
    p = pos_in_line;
    n = nibble_of(c);
    made = 1'b0;
    r = '0;
    if (eof_reached) return 1'b0;
    if (c == CHAR_NEWLINE) begin
      pos_in_line = '0;
      in_record = 1'b0;
      rec_kind = REC_IGNORED;
      return 1'b0;
    end
    // The position sticks at its top value, so an over-long line never looks like a
    // fresh one.
    pos_in_line = (p < POS_MAX) ? p + 10'd1 : POS_MAX;
    if (p == '0) begin
      in_record = (c == CHAR_COLON);
      rec_bytes = '0;
      rec_addr = '0;
      rec_kind = REC_IGNORED;
      return 1'b0;
    end
    if (!in_record) return 1'b0;
    if (p == 10'd1) begin
      held_nibble = n;
    end else if (p == 10'd2) begin
      rec_bytes = {held_nibble, n};
    end else if (p <= 10'd6) begin
      rec_addr = {1'b0, rec_addr[11:0], n};
    end else if (p == 10'd7) begin
      type_first = c;
    end else if (p == 10'd8) begin
      // The type characters must match exactly; any other pair leaves the record ignored.
      rec_kind = REC_IGNORED;
      if (type_first == CHAR_ZERO && c == CHAR_ZERO) begin
        if (!ext_sticky) rec_kind = REC_DATA;
      end else if (type_first == CHAR_ZERO && c == CHAR_FOUR) begin
        rec_kind = REC_EXTENDED;
        ext_sticky = 1'b1;
      end else if (type_first == CHAR_ZERO && c == CHAR_ONE) begin
        rec_kind = REC_EOF;
        eof_reached = 1'b1;
        r.kind = KIND_EOF;
        r.bounds_error_seen = bnd_sticky;
        r.extended_seen = ext_sticky;
        made = 1'b1;
      end
    end else if (p[0]) begin
      held_nibble = n;
    end else if (rec_kind == REC_DATA) begin
      k = (32'(p) - 32'd10) >> 1;
      // Characters past the last data byte are ignored.
      if (k < 32'(rec_bytes)) begin
        a = rec_addr + k[AddrW-1:0];
        if (a >= lo_limit && a < hi_limit) begin
          r.kind = KIND_ACCEPT;
        end else begin
          r.kind = KIND_REJECT;
          bnd_sticky = 1'b1;
        end
        r.address = a;
        r.data = {held_nibble, n};
        r.bounds_error_seen = bnd_sticky;
        r.extended_seen = ext_sticky;
        made = 1'b1;
      end
    end
    return made;
  endfunction

  task automatic report_mismatch(input string what, input logic [AddrW-1:0] want,
                                 input logic [AddrW-1:0] got);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // Every accepted character goes through the predictor in the order of acceptance, and
  // every accepted result is held against the oldest outstanding expectation. Rows of
  // the directed table that carry typed-in results use those instead of the prediction,
  // though the predictor still sees their characters to keep its state in step.
  always @(posedge clk) begin : scoreboard
    ihex_result_t model;
    ihex_result_t want;
    if (char_valid && !char_stall) begin
      if (step_parser(char_value, model)) begin
        if (char_typed && fixed_results.size() != 0) begin
          results_due.push_back(fixed_results.pop_front());
        end else begin
          results_due.push_back(model);
        end
      end
    end
    if (res_valid && !res_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding, address", '0, res_address);
      end else begin
        want = results_due.pop_front();
        if (want.kind !== res_kind) begin
          report_mismatch("kind", 17'(want.kind), 17'(res_kind));
        end
        if (want.address !== res_address) begin
          report_mismatch("address", want.address, res_address);
        end
        if (want.data !== res_data) begin
          report_mismatch("data", 17'(want.data), 17'(res_data));
        end
        if (want.bounds_error_seen !== res_bounds) begin
          report_mismatch("bounds flag", 17'(want.bounds_error_seen), 17'(res_bounds));
        end
        if (want.extended_seen !== res_ext) begin
          report_mismatch("extended flag", 17'(want.extended_seen), 17'(res_ext));
        end
      end
    end
  end

  // Result back-pressure: mostly short stalls or short stall-free stretches, a few long
  // stalls, and now and then a long stretch with no stall at all.
  always @(posedge clk) begin : result_stall_gen
    int unsigned roll;
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        res_stall <= 1'b0;
        stall_left = $urandom_range(20, 80);
      end else if (roll < 37) begin
        res_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (roll < 40) begin
        res_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end else begin
        res_stall <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end
    end
  end

  // Idle cycles after an item on the sending side, shaped like the stalls above.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (send_calm != 0) begin
      send_calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      send_calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one character and holds it until it is taken. Valid stays high into the next
  // item when no gap follows, so it is never lowered and raised in the same step.
  task automatic send_char(input logic [7:0] c, input bit typed);
    int unsigned gap;
    char_value <= c;
    char_typed <= typed;
    char_valid <= 1'b1;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends the buffered line and reports how many characters it held.
  task automatic send_line(input bit typed, output int unsigned counted);
    counted = line_buf.size();
    foreach (line_buf[i]) send_char(line_buf[i], typed);
  endtask

  task automatic send_text(input string s, input bit typed);
    int unsigned dummy;
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line(typed, dummy);
  endtask

  // Stops sending and waits until every outstanding result has come, then lets the
  // pipeline empty of characters that cause none.
  task automatic drain();
    char_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_bounds(input logic [AddrW-1:0] lo, input logic [AddrW-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_LOWER_BOUND;
    cfg_data <= lo;
    @(posedge clk);
    lo_limit = lo;
    cfg_index <= REG_UPPER_BOUND;
    cfg_data <= hi;
    @(posedge clk);
    hi_limit = hi;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
    return c;
  endfunction

  // Hex digit of either case.
  function automatic logic [7:0] digit_char(input logic [3:0] v);
    logic [7:0] base;
    if (v < 4'd10) return "0" + {4'd0, v};
    base = ($urandom_range(0, 1) != 0) ? "A" : "a";
    return base + {4'd0, v} - 8'd10;
  endfunction

  function automatic void push_hex_byte(input logic [7:0] b);
    line_buf.push_back(digit_char(b[7:4]));
    line_buf.push_back(digit_char(b[3:0]));
  endfunction

  // A type 00 record with its load address mostly close to one of the bounds, so that
  // the bytes straddle it. Some lines are cut short, some carry a stray
  // character and some trailing junk; a stray character never replaces a type character.
  function automatic void compose_data_record();
    int          cnt;
    int          base;
    int          addr;
    int          cut;
    int          j;
    int unsigned roll;
    logic [15:0] a16;
    roll = $urandom_range(0, 99);
    if (roll < 90) begin
      cnt = $urandom_range(0, 6);
    end else if (roll < 99) begin
      cnt = $urandom_range(7, 24);
    end else begin
      cnt = $urandom_range(25, 255);
    end
    case ($urandom_range(0, 4))
      0, 1: base = int'(lo_limit);
      2, 3: base = int'(hi_limit);
      default: base = $urandom_range(0, 65535);
    endcase
    addr = base - cnt - 1 + int'($urandom_range(0, cnt + 3));
    if (addr < 0) addr = 0;
    if (addr > 65535) addr = 65535;
    a16 = addr[15:0];
    line_buf.push_back(CHAR_COLON);
    push_hex_byte(8'(cnt));
    push_hex_byte(a16[15:8]);
    push_hex_byte(a16[7:0]);
    line_buf.push_back(CHAR_ZERO);
    line_buf.push_back(CHAR_ZERO);
    repeat (cnt + 1) push_hex_byte(8'($urandom_range(0, 255)));
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      j = $urandom_range(1, line_buf.size() - 1);
      if (j == 7 || j == 8) j = j - 6;
      line_buf[j] = noise_char();
    end else if (roll < 20) begin
      cut = $urandom_range(1, line_buf.size() - 1);
      while (line_buf.size() > cut) void'(line_buf.pop_back());
    end else if (roll < 35) begin
      repeat ($urandom_range(1, 5)) line_buf.push_back(noise_char());
    end
    line_buf.push_back(CHAR_NEWLINE);
  endfunction

  // A record whose type pair matches none of the known ones, often a near miss.
  function automatic void compose_ignored_record();
    logic [7:0] t1;
    logic [7:0] t2;
    line_buf.push_back(CHAR_COLON);
    repeat (6) line_buf.push_back(noise_char());
    t1 = ($urandom_range(0, 1) != 0) ? CHAR_ZERO : noise_char();
    t2 = noise_char();
    while (t1 == CHAR_ZERO && (t2 == CHAR_ZERO || t2 == CHAR_ONE || t2 == CHAR_FOUR)) begin
      t2 = noise_char();
    end
    line_buf.push_back(t1);
    line_buf.push_back(t2);
    repeat ($urandom_range(0, 10)) line_buf.push_back(noise_char());
    line_buf.push_back(CHAR_NEWLINE);
  endfunction

  function automatic void compose_random_line();
    logic [7:0]  first;
    int unsigned roll;
    line_buf.delete();
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      compose_data_record();
    end else if (roll < 82) begin
      compose_ignored_record();
    end else if (roll < 95) begin
      do first = noise_char(); while (first == CHAR_COLON);
      line_buf.push_back(first);
      repeat ($urandom_range(0, 15)) line_buf.push_back(noise_char());
      line_buf.push_back(CHAR_NEWLINE);
    end else begin
      line_buf.push_back(CHAR_NEWLINE);
    end
  endfunction

  initial begin : stimulus
    int unsigned      phase_items;
    int unsigned      counted;
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
    // Results of the typed rows, in the order they fall due.
    fixed_results.push_back(ihex_result_t'{KIND_ACCEPT, 17'h07FFF, 8'hFF, 1'b0, 1'b0});
    fixed_results.push_back(ihex_result_t'{KIND_REJECT, 17'h08000, 8'h00, 1'b1, 1'b0});
    fixed_results.push_back(ihex_result_t'{KIND_REJECT, 17'h003FF, 8'hA5, 1'b1, 1'b0});
    fixed_results.push_back(ihex_result_t'{KIND_ACCEPT, 17'h00400, 8'hC3, 1'b1, 1'b0});
    fixed_results.push_back(ihex_result_t'{KIND_EOF, 17'h00000, 8'h00, 1'b1, 1'b1});
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The opening rows check the bounds that reset leaves behind.
    for (int i = 0; i < OpenRows; i++) send_text(dir_text[i], dir_typed[i]);

    // Each phase starts from an empty pipeline, so the sender has waited for every
    // outstanding result before the bounds change.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: begin lo = '0;       hi = AddrSpan; end
        1: begin lo = AddrSpan; hi = '0;       end
        2: begin lo = 17'h08000; hi = 17'h08000; end
        5: begin lo = LOWER_RESET; hi = UPPER_RESET; end
        default: begin
          lo = 17'($urandom_range(0, 65536));
          hi = 17'($urandom_range(0, 65536));
        end
      endcase
      write_bounds(lo, hi);
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        compose_random_line();
        send_line(1'b0, counted);
        phase_items += counted;
      end
    end

    // Closing rows: a window over every 16-bit address, then the records that change the parser for good.
    drain();
    write_bounds('0, AddrSpan);
    for (int i = OpenRows; i < DirRows; i++) send_text(dir_text[i], dir_typed[i]);
    drain();

    if (mismatches == 0) begin
      $display("intel_hex_record_parser_tb: clean");
    end else begin
      $display("intel_hex_record_parser_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #RunLimit;
    $display("intel_hex_record_parser_tb: errors");
    $finish;
  end

endmodule
